@@ rtl/fvt_pkg.sv @@
// ============================================================================
// fvt_pkg: shared types and constants of the frustum visibility test
// Query word layout, query kind codes and plane register packing.
// ============================================================================
package fvt_pkg;

  // Number of planes that take part in the test, one cell per plane.
  localparam int unsigned NUM_PLANES = 6;

  // Plane register: nx, ny, nz (12 bit Q1.10) then d (24 bit Q15.8).
  localparam int unsigned PLANE_W   = 60;
  localparam int unsigned NORM_W    = 12;
  localparam int unsigned NORM_FRAC = 10;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned SIZE_W    = 23;

  localparam int unsigned NX_LSB = 0;
  localparam int unsigned NY_LSB = 12;
  localparam int unsigned NZ_LSB = 24;
  localparam int unsigned D_LSB  = 36;

  // Corner coordinate, product and distance sum widths.
  localparam int unsigned CRN_W  = COORD_W + 1;
  localparam int unsigned PROD_W = NORM_W + CRN_W;
  localparam int unsigned SUM_W  = PROD_W + 3;

  localparam int unsigned CFG_IDX_W = 3;

  // Query kind codes.
  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_BOX    = 2'd1;
  localparam logic [1:0] KIND_SPHERE = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  // One query as it travels along the chain, with its running verdict.
  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [SIZE_W-1:0]         size_x;
    logic [SIZE_W-1:0]         size_y;
    logic [SIZE_W-1:0]         size_z;
    logic [SIZE_W-1:0]         radius;
    logic                      visible;
  } qry_t;

endpackage

@@ rtl/fvt_cell.sv @@
// ============================================================================
// fvt_cell: one plane of the frustum test chain
// Holds one plane register, multiplies in a first stage and sums and
// compares in a second, then hands the query to the next cell.
// ============================================================================
module fvt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         plane_we_i,
  input  logic [fvt_pkg::PLANE_W-1:0]  plane_wdata_i,
  input  logic                         in_valid_i,
  input  fvt_pkg::qry_t                in_qry_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  output fvt_pkg::qry_t                out_qry_o,
  input  logic                         out_ready_i
);
  import fvt_pkg::*;

  logic [PLANE_W-1:0] plane_q;

  logic signed [NORM_W-1:0]  nx, ny, nz;
  logic signed [CRN_W-1:0]   cx, cy, cz;
  logic signed [PROD_W-1:0]  px_d, py_d, pz_d;
  logic signed [PROD_W-1:0]  px_q, py_q, pz_q;
  logic                      valid_a_q, valid_b_q;
  qry_t                      qry_a_q, qry_b_q, qry_b_d;
  logic                      ready_a, ready_b;
  logic                      is_box;
  logic signed [SUM_W-1:0]   d_term, bias_term, sum;
  logic                      pass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (plane_we_i) begin
      plane_q <= plane_wdata_i;
    end
  end

  assign nx = plane_q[NX_LSB +: NORM_W];
  assign ny = plane_q[NY_LSB +: NORM_W];
  assign nz = plane_q[NZ_LSB +: NORM_W];

  // For a box, the corner farthest along the normal decides the plane test.
  assign is_box = (in_qry_i.kind == KIND_BOX);
  assign cx = (is_box && !nx[NORM_W-1])
            ? CRN_W'(in_qry_i.pos_x) + $signed({2'b00, in_qry_i.size_x})
            : CRN_W'(in_qry_i.pos_x);
  assign cy = (is_box && !ny[NORM_W-1])
            ? CRN_W'(in_qry_i.pos_y) + $signed({2'b00, in_qry_i.size_y})
            : CRN_W'(in_qry_i.pos_y);
  assign cz = (is_box && !nz[NORM_W-1])
            ? CRN_W'(in_qry_i.pos_z) + $signed({2'b00, in_qry_i.size_z})
            : CRN_W'(in_qry_i.pos_z);

  assign px_d = PROD_W'(nx) * PROD_W'(cx);
  assign py_d = PROD_W'(ny) * PROD_W'(cy);
  assign pz_d = PROD_W'(nz) * PROD_W'(cz);

  assign ready_b    = !valid_b_q || out_ready_i;
  assign ready_a    = !valid_a_q || ready_b;
  assign in_ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= in_valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      qry_a_q <= in_qry_i;
      px_q    <= px_d;
      py_q    <= py_d;
      pz_q    <= pz_d;
    end
    if (ready_b && valid_a_q) begin
      qry_b_q <= qry_b_d;
    end
  end

  // Second stage: distance plus scaled offset, with the scaled radius added
  // for spheres so that the sphere test becomes a compare against zero.
  assign d_term    = SUM_W'($signed({plane_q[D_LSB +: COORD_W], {NORM_FRAC{1'b0}}}));
  assign bias_term = (qry_a_q.kind == KIND_SPHERE)
                   ? SUM_W'({qry_a_q.radius, {NORM_FRAC{1'b0}}})
                   : '0;
  assign sum = SUM_W'(px_q) + SUM_W'(py_q) + SUM_W'(pz_q) + d_term + bias_term;

  always_comb begin
    case (qry_a_q.kind)
      KIND_SPHERE: pass = !sum[SUM_W-1] && (sum != '0);
      KIND_RSVD:   pass = 1'b1;
      default:     pass = !sum[SUM_W-1];
    endcase
    qry_b_d         = qry_a_q;
    qry_b_d.visible = qry_a_q.visible && pass;
  end

  assign out_valid_o = valid_b_q;
  assign out_qry_o   = qry_b_q;

endmodule

@@ rtl/frustum_visibility_test_top.sv @@
// ============================================================================
// frustum_visibility_test_top: six-plane view frustum visibility test
// Streams point, box and sphere queries through a chain of plane cells.
// ============================================================================
//
// Usage: software loads the frustum planes through the write port
// (cfg_we_i, cfg_idx_i, cfg_wdata_i), one 60-bit register per plane, index 0
// to 5 for right, left, bottom, top, far and near. A write takes effect at
// the clock edge where cfg_we_i is high; indexes beyond the last plane are
// ignored. Planes must be written only while no query is in flight; the
// block itself does not enforce it. Queries enter on the s_axis channel,
// one word per query, and each query produces exactly one result word on
// the m_axis channel carrying the visible flag. The chain has one cell per
// plane and each cell has two register stages (multiply, then sum and
// compare), so a query passes 2 * NUM_PLANES (12) stages on its way to
// the result word. While no receiver stall has filled the chain, a new
// query is accepted every cycle; throughput is one word per cycle.
// When the receiver stalls, the result holds in the last stage and the
// stall moves back stage by stage, so empty stages still take new words
// until the chain is full. Reset clears all planes to zero and empties
// the chain.
//
module frustum_visibility_test_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [fvt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fvt_pkg::PLANE_W-1:0]      cfg_wdata_i,
  // Query input.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: pos_x, pos_y, pos_z, size_x, size_y, size_z,
  // sphere_radius, zero padding.
  input  logic [167:0]                     s_axis_tdata,
  // Fields from bit 0: req_type.
  input  logic [1:0]                       s_axis_tuser,
  // Result output.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: visible, zero padding.
  output logic [7:0]                       m_axis_tdata
);
  import fvt_pkg::*;

  logic [NUM_PLANES:0] vld;
  logic [NUM_PLANES:0] rdy;
  qry_t                qry [NUM_PLANES+1];
  qry_t                in_qry;

  // Unpack the input word; every query starts out visible.
  always_comb begin
    in_qry.kind    = s_axis_tuser;
    in_qry.pos_x   = s_axis_tdata[23:0];
    in_qry.pos_y   = s_axis_tdata[47:24];
    in_qry.pos_z   = s_axis_tdata[71:48];
    in_qry.size_x  = s_axis_tdata[94:72];
    in_qry.size_y  = s_axis_tdata[117:95];
    in_qry.size_z  = s_axis_tdata[140:118];
    in_qry.radius  = s_axis_tdata[163:141];
    in_qry.visible = 1'b1;
  end

  assign vld[0]        = s_axis_tvalid;
  assign qry[0]        = in_qry;
  assign s_axis_tready = rdy[0];

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    logic plane_we;

    // Each cell owns one plane register; decode the write index here.
    assign plane_we = cfg_we_i && (cfg_idx_i == CFG_IDX_W'(i));

    fvt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .plane_we_i    (plane_we),
      .plane_wdata_i (cfg_wdata_i),
      .in_valid_i    (vld[i]),
      .in_qry_i      (qry[i]),
      .in_ready_o    (rdy[i]),
      .out_valid_o   (vld[i+1]),
      .out_qry_o     (qry[i+1]),
      .out_ready_i   (rdy[i+1])
    );
  end

  // The last cell's second stage serves as the output register.
  assign rdy[NUM_PLANES] = m_axis_tready;
  assign m_axis_tvalid   = vld[NUM_PLANES];
  assign m_axis_tdata    = {7'b0, qry[NUM_PLANES].visible};

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frustum visibility test bench
// Streams point, box and sphere queries through the six-plane visibility
// block under several plane settings. Every query is scored by an exact
// wide-integer predictor, and each result word is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import fvt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * NUM_PLANES + 4;
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;
  localparam int UNIT_NORMAL = 1024;

  typedef struct {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [SIZE_W-1:0]         size_x;
    logic [SIZE_W-1:0]         size_y;
    logic [SIZE_W-1:0]         size_z;
    logic [SIZE_W-1:0]         radius;
  } query_t;

  // Holds a copy of the plane registers and the visible flags still owed.
  class visibility_scoreboard;
    logic [PLANE_W-1:0] planes[NUM_PLANES];
    bit                 owed_visible[$];
    int unsigned        mismatches;

    function new();
      for (int i = 0; i < NUM_PLANES; i++) planes[i] = '0;
      mismatches = 0;
    endfunction

    function void load_plane(int unsigned idx, logic [PLANE_W-1:0] value);
      if (idx < NUM_PLANES) planes[idx] = value;
    endfunction

    // Signed distance with 18 fraction bits; the offset is aligned to the
    // products by shifting it up by the normal fraction bits.
    function longint plane_distance(int unsigned i, longint x, longint y, longint z);
      longint nx, ny, nz, d;
      nx = $signed(planes[i][NX_LSB +: NORM_W]);
      ny = $signed(planes[i][NY_LSB +: NORM_W]);
      nz = $signed(planes[i][NZ_LSB +: NORM_W]);
      d  = $signed(planes[i][D_LSB +: COORD_W]);
      return nx * x + ny * y + nz * z + d * (longint'(1) << NORM_FRAC);
    endfunction

    function bit visible_of(query_t q);
      longint px, py, pz, rad;
      bit     in_front;
      px  = q.pos_x;
      py  = q.pos_y;
      pz  = q.pos_z;
      rad = longint'(q.radius) << NORM_FRAC;
      if (q.kind == KIND_RSVD) return 1'b1;
      for (int i = 0; i < NUM_PLANES; i++) begin
        case (q.kind)
          KIND_POINT: in_front = plane_distance(i, px, py, pz) >= 0;
          KIND_BOX: begin
            // A box survives a plane when any one of its corners is in front.
            in_front = 1'b0;
            for (int c = 0; c < 8; c++) begin
              if (plane_distance(i, px + (c[0] ? longint'(q.size_x) : 0),
                                 py + (c[1] ? longint'(q.size_y) : 0),
                                 pz + (c[2] ? longint'(q.size_z) : 0)) >= 0)
                in_front = 1'b1;
            end
          end
          default: in_front = plane_distance(i, px, py, pz) > -rad;
        endcase
        if (!in_front) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_query(query_t q);
      owed_visible.push_back(visible_of(q));
    endfunction

    function void check_result(bit got);
      bit want;
      if (owed_visible.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, visible %0b", got);
      end else begin
        want = owed_visible.pop_front();
        if (want != got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("visible mismatch at %0t: expected %0b got %0b", $realtime, want, got);
        end
      end
    endfunction

    function int unsigned outstanding();
      return owed_visible.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PLANE_W-1:0]   cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [167:0]         s_axis_tdata;  // pos_x, pos_y, pos_z, size_x..z, radius, pad
  logic [1:0]           s_axis_tuser;  // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;  // visible, pad

  visibility_scoreboard sb = new();

  // Both sides run without idling while this is set.
  bit          steady;
  int unsigned cycles = 0;
  // Region that random queries are drawn around.
  int          region_c[3];
  int          region_e;

  frustum_visibility_test_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver stalls in about a third of the cycles.
  always @(posedge clk_i) m_axis_tready <= steady || ($urandom_range(99) >= 35);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[0]);
  end

  function automatic logic [PLANE_W-1:0] plane_word(int nx, int ny, int nz, int d);
    logic [NORM_W-1:0]  bx, by, bz;
    logic [COORD_W-1:0] bd;
    bx = nx[NORM_W-1:0];
    by = ny[NORM_W-1:0];
    bz = nz[NORM_W-1:0];
    bd = d[COORD_W-1:0];
    return {bd, bz, by, bx};
  endfunction

  // Inward normal direction along the plane's axis, in register order.
  function automatic int plane_sign(int i);
    return (i == 0 || i == 3 || i == 4) ? -1 : 1;
  endfunction

  function automatic query_t mk(logic [1:0] kind, int x, int y, int z,
                                int sx, int sy, int sz, int r);
    query_t q;
    q.kind   = kind;
    q.pos_x  = x[COORD_W-1:0];
    q.pos_y  = y[COORD_W-1:0];
    q.pos_z  = z[COORD_W-1:0];
    q.size_x = sx[SIZE_W-1:0];
    q.size_y = sy[SIZE_W-1:0];
    q.size_z = sz[SIZE_W-1:0];
    q.radius = r[SIZE_W-1:0];
    return q;
  endfunction

  function automatic int near_coord(int c, int span);
    longint v;
    v = longint'(c) + longint'($urandom_range(0, 2 * span)) - span;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return int'(v);
  endfunction

  // Mostly queries near the current region; a tenth span the full field range
  // so that every bit of every field is exercised.
  function automatic query_t random_query();
    query_t     q;
    logic [1:0] kind;
    kind = ($urandom_range(99) < 5) ? KIND_RSVD : 2'($urandom_range(2));
    if ($urandom_range(99) < 10) begin
      q = mk(kind, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom());
    end else begin
      q = mk(kind, near_coord(region_c[0], region_e), near_coord(region_c[1], region_e),
             near_coord(region_c[2], region_e), $urandom_range(0, region_e),
             $urandom_range(0, region_e), $urandom_range(0, region_e),
             $urandom_range(0, region_e));
    end
    return q;
  endfunction

  task automatic send_query(query_t q);
    while (!steady && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.kind;
    s_axis_tdata  <= {4'b0, q.radius, q.size_z, q.size_y, q.size_x,
                      q.pos_z, q.pos_y, q.pos_x};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_query(q);
  endtask

  // Drops valid and waits until every owed result is back and the chain is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes one register; the caller drops the write enable after a batch.
  task automatic write_plane(int unsigned idx, logic [PLANE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx[CFG_IDX_W-1:0];
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.load_plane(idx, value);
  endtask

  task automatic load_all(logic [PLANE_W-1:0] value);
    for (int i = 0; i < NUM_PLANES; i++) write_plane(i, value);
    cfg_we_i <= 1'b0;
  endtask

  // Builds a box-shaped frustum of half extent e around a center, with each
  // normal optionally tilted by up to tilt units on its off-axis components.
  task automatic load_frustum(int cx, int cy, int cz, int e, int tilt);
    int n[3];
    int axis;
    int s;
    region_c[0] = cx;
    region_c[1] = cy;
    region_c[2] = cz;
    region_e    = e;
    for (int i = 0; i < NUM_PLANES; i++) begin
      axis = i / 2;
      s    = plane_sign(i);
      for (int a = 0; a < 3; a++)
        n[a] = (tilt > 0) ? int'($urandom_range(0, 2 * tilt)) - tilt : 0;
      n[axis] = s * UNIT_NORMAL;
      write_plane(i, plane_word(n[0], n[1], n[2], e - s * region_c[axis]));
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int               e;
    int               c[3];
    int               count;
    logic [PLANE_W-1:0] w;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    steady        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Planes after reset are all zero: every distance is zero, so only a
    // sphere of radius zero is culled.
    send_query(mk(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk(KIND_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                  COORD_MAX, 0));
    send_query(mk(KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk(KIND_SPHERE, COORD_MAX, COORD_MIN, 0, 0, 0, 0, COORD_MAX));
    send_query(mk(KIND_RSVD, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk(KIND_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, COORD_MAX));
    drain();

    // Writes to indexes past the last plane must leave the planes alone.
    write_plane(6, '1);
    write_plane(7, plane_word(UNIT_NORMAL, UNIT_NORMAL, UNIT_NORMAL, COORD_MAX));
    cfg_we_i <= 1'b0;
    send_query(mk(KIND_SPHERE, 5, 5, 5, 0, 0, 0, 0));

    drain();
    e = 256000;
    load_frustum(0, 0, 0, e, 0);
    send_query(mk(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk(KIND_POINT, e, 0, 0, 0, 0, 0, 0));
    // One point just past each plane in turn.
    for (int i = 0; i < NUM_PLANES; i++) begin
      c = '{0, 0, 0};
      c[i / 2] = -plane_sign(i) * (e + 1);
      send_query(mk(KIND_POINT, c[0], c[1], c[2], 0, 0, 0, 0));
    end
    send_query(mk(KIND_BOX, e + 1, 0, 0, 10, 10, 10, 0));
    send_query(mk(KIND_BOX, e - 5, 0, 0, 10, 10, 10, 0));
    send_query(mk(KIND_BOX, -e - 1000, 0, 0, 500, 0, 0, 0));
    send_query(mk(KIND_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                  COORD_MAX, 0));
    // A sphere touching a plane from outside is culled; one unit larger is not.
    send_query(mk(KIND_SPHERE, e + 100, 0, 0, 0, 0, 0, 100));
    send_query(mk(KIND_SPHERE, e + 100, 0, 0, 0, 0, 0, 101));
    send_query(mk(KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk(KIND_RSVD, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0));
    send_query(mk(KIND_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0));
    drain();

    // Random phases: extreme and random plane words first, then box-shaped
    // frustums, the later ones with tilted normals.
    for (int phase = 0; phase < 10; phase++) begin
      if (phase < 4) begin
        region_c = '{0, 0, 0};
        region_e = 4000000;
        count    = 60;
        case (phase)
          0: load_all(plane_word(2047, 2047, 2047, COORD_MAX));
          1: load_all(plane_word(-2048, -2048, -2048, COORD_MIN));
          2: load_all('1);
          default: begin
            for (int i = 0; i < NUM_PLANES; i++) begin
              w[31:0]  = $urandom();
              w[59:32] = 28'($urandom());
              write_plane(i, w);
            end
            cfg_we_i <= 1'b0;
          end
        endcase
      end else begin
        count = 215;
        load_frustum(int'($urandom_range(0, 400000)) - 200000,
                     int'($urandom_range(0, 400000)) - 200000,
                     int'($urandom_range(0, 400000)) - 200000,
                     $urandom_range(256, 300000), (phase >= 7) ? 200 : 0);
      end
      steady = (phase == 6);
      for (int k = 0; k < count; k++) send_query(random_query());
      drain();
      steady = 1'b0;
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
